// ----- sv/dfw_pkg.sv -----
// shared types and constants for the depth-first graph walker
// no dependencies; imported by every walker module

package dfw_pkg;

	localparam int NODES      = 32;
	localparam int MAX_DEGREE = 8;

	localparam int NODE_W  = $clog2(NODES);
	localparam int SLOT_W  = $clog2(MAX_DEGREE);
	localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
	localparam int DEPTH_W = $clog2(NODES + 1);
	localparam int NB_AW   = $clog2(NODES * MAX_DEGREE);
	localparam int OP_W    = 2;

	// request operation codes
	localparam logic [OP_W-1:0] OP_NB_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEG_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_TRAVERSE  = 2'd2;
	localparam logic [OP_W-1:0] OP_SEARCH    = 2'd3;

	// result kinds
	localparam logic KIND_NODE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// access to the adjacency store
	typedef struct packed {
		logic              nb_we;
		logic              nb_re;
		logic              deg_we;
		logic [NODE_W-1:0] node;
		logic [SLOT_W-1:0] slot;
		logic [NODE_W-1:0] nb;
		logic [DEG_W-1:0]  deg;
	} adj_req_t;

	// access to the walk stack
	typedef struct packed {
		logic              we;
		logic              re;
		logic [NODE_W-1:0] waddr;
		logic [NODE_W-1:0] raddr;
		logic [NODE_W-1:0] wdata;
	} stk_req_t;

	// sequencer states
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_OUTER = 7'b0000010,
		S_POP   = 7'b0000100,
		S_TOP   = 7'b0001000,
		S_EMIT  = 7'b0010000,
		S_NB    = 7'b0100000,
		S_END   = 7'b1000000
	} state_t;

	// clamp a degree to the list length
	function automatic logic [DEG_W-1:0] sat_degree(input logic [3:0] d);
		logic [DEG_W-1:0] r;
		if (32'(d) > MAX_DEGREE) begin
			r = DEG_W'(MAX_DEGREE);
		end else begin
			r = DEG_W'(d);
		end
		return r;
	endfunction

endpackage

// ----- sv/graph_depth_first_walker_top.sv -----
// Depth-first walker over a 32-node adjacency table with up to 8 neighbors per node.
//
// Request channel (req_valid / req_stall): operation 0 writes one neighbor entry,
// operation 1 sets a node's degree (clamped to 8), operation 2 runs a full
// traversal, operation 3 searches from node to goal. A request is taken on a
// rising edge with req_valid high and req_stall low.
// Result channel (res_valid / res_stall): one result per popped node (kind 0), except
// a search's goal node, then one end result (kind 1, last 1, goal_found for search).
// Table writes give no result. A run holds req_stall high until its end result
// has been loaded into the output register.
// Sequence: each popped node goes through pop, stack read, emit, a read per
// neighbor entry and a last check, set by the single-port neighbor memory and
// the registered stack read. A walk that empties its stack takes a further pop,
// the end result a step of its own; full traversal scans each node in an outer step.
// A search's first node result follows pop, stack read and emit; a traversal scans first.
// The output register lets the walk produce the next result while the current one
// waits; a stalled receiver holds the walk at its next result.
// Reset (arst_n low) clears degrees, visited marks, stack pointer and handshake
// state; neighbor entries are undefined until written.

module graph_depth_first_walker_top
	import dfw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] operation,
	input  logic [4:0] node,
	input  logic [2:0] slot,
	input  logic [4:0] neighbor,
	input  logic [3:0] degree,
	input  logic [4:0] goal,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [4:0] visited_node,
	output logic       goal_found,
	output logic       last
);

	adj_req_t          adj;
	stk_req_t          stk;
	logic [NODE_W-1:0] nb_rdata;
	logic [DEG_W-1:0]  deg_rdata;
	logic [NODE_W-1:0] stk_rdata;

	// sequencer
	dfw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.node         (node),
		.slot         (slot),
		.neighbor     (neighbor),
		.degree       (degree),
		.goal         (goal),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.visited_node (visited_node),
		.goal_found   (goal_found),
		.last         (last),
		.adj          (adj),
		.nb_rdata     (nb_rdata),
		.deg_rdata    (deg_rdata),
		.stk          (stk),
		.stk_rdata    (stk_rdata)
	);

	// adjacency store
	dfw_adj u_adj (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (adj),
		.nb_rdata  (nb_rdata),
		.deg_rdata (deg_rdata)
	);

	// walk stack
	dfw_stack u_stack (
		.clk   (clk),
		.req   (stk),
		.rdata (stk_rdata)
	);

endmodule

// ----- sv/dfw_adj.sv -----
// adjacency store: neighbor memory (sync read) and per-node degree table
// depends on dfw_pkg

module dfw_adj
	import dfw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  adj_req_t          req,
	output logic [NODE_W-1:0] nb_rdata,
	output logic [DEG_W-1:0]  deg_rdata
);

	logic [NODE_W-1:0] nb_mem [NODES*MAX_DEGREE];
	logic [DEG_W-1:0]  deg_q  [NODES];
	logic [NB_AW-1:0]  nb_addr;

	// entry address: node row, slot column
	assign nb_addr = NB_AW'(req.node) * NB_AW'(MAX_DEGREE) + NB_AW'(req.slot);

	// neighbor memory, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (req.nb_we) begin
			nb_mem[nb_addr] <= req.nb;
		end
		if (req.nb_re) begin
			nb_rdata <= nb_mem[nb_addr];
		end
	end

	// degree table, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				deg_q[i] <= '0;
			end
		end else if (req.deg_we) begin
			deg_q[req.node] <= req.deg;
		end
	end

	assign deg_rdata = deg_q[req.node];

endmodule

// ----- sv/dfw_stack.sv -----
// walk stack memory, one write and one registered read per cycle
// depends on dfw_pkg

module dfw_stack
	import dfw_pkg::*;
(
	input  logic              clk,
	input  stk_req_t          req,
	output logic [NODE_W-1:0] rdata
);

	logic [NODE_W-1:0] mem [NODES];

	// write at depth, read at top
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ----- sv/dfw_ctrl.sv -----
// walk sequencer: request decode, visited marks, stack pointer, result register
// depends on dfw_pkg; drives dfw_adj and dfw_stack

module dfw_ctrl
	import dfw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        operation,
	input  logic [4:0]        node,
	input  logic [2:0]        slot,
	input  logic [4:0]        neighbor,
	input  logic [3:0]        degree,
	input  logic [4:0]        goal,
	output logic              res_valid,
	input  logic              res_stall,
	output logic              kind,
	output logic [4:0]        visited_node,
	output logic              goal_found,
	output logic              last,
	output adj_req_t          adj,
	input  logic [NODE_W-1:0] nb_rdata,
	input  logic [DEG_W-1:0]  deg_rdata,
	output stk_req_t          stk,
	input  logic [NODE_W-1:0] stk_rdata
);

	state_t             state_q;
	logic [NODES-1:0]   visited_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] outer_q;
	logic               searching_q;
	logic               found_q;
	logic               chk_s1;
	logic               res_valid_q;
	logic [NODE_W-1:0]  cur_q;
	logic [NODE_W-1:0]  goal_q;
	logic [DEG_W-1:0]   k_q;
	logic               kind_q;
	logic [NODE_W-1:0]  node_q;
	logic               found_out_q;
	logic               last_q;

	logic               accept;
	logic               out_free;
	logic               emit_node;
	logic               emit_end;
	logic               push_en;
	logic [NODE_W-1:0]  push_node;
	logic               outer_done;
	logic               room;

	assign accept     = req_valid && (state_q == S_IDLE);
	assign req_stall  = (state_q != S_IDLE);
	assign out_free   = !res_valid_q || !res_stall;
	assign emit_node  = (state_q == S_EMIT) && out_free;
	assign emit_end   = (state_q == S_END) && out_free;
	assign outer_done = (outer_q == DEPTH_W'(NODES));
	assign room       = (depth_q < DEPTH_W'(NODES));

	// memory requests and push decision
	always_comb begin
		adj       = '0;
		stk       = '0;
		push_en   = 1'b0;
		push_node = nb_rdata;
		stk.raddr = NODE_W'(depth_q - DEPTH_W'(1));
		stk.waddr = NODE_W'(depth_q);
		unique case (state_q)
			S_IDLE: begin
				adj.node   = node;
				adj.slot   = slot;
				adj.nb     = neighbor;
				adj.deg    = sat_degree(degree);
				adj.nb_we  = accept && (operation == OP_NB_WRITE);
				adj.deg_we = accept && (operation == OP_DEG_WRITE);
				stk.waddr  = '0;
				stk.wdata  = node;
				stk.we     = accept && (operation == OP_SEARCH);
			end
			S_OUTER: begin
				push_node = NODE_W'(outer_q);
				push_en   = !outer_done && !visited_q[NODE_W'(outer_q)] && room;
			end
			S_POP: begin
				stk.re = (depth_q != '0);
			end
			S_TOP: begin
			end
			S_EMIT: begin
				adj.node = cur_q;
			end
			S_NB: begin
				adj.node  = cur_q;
				adj.slot  = SLOT_W'(k_q - DEG_W'(1));
				adj.nb_re = (k_q != '0);
				push_en   = chk_s1 && !visited_q[nb_rdata] && room;
			end
			S_END: begin
			end
			default: begin
			end
		endcase
		if (state_q != S_IDLE) begin
			stk.we    = push_en;
			stk.wdata = push_node;
		end
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			visited_q   <= '0;
			depth_q     <= '0;
			outer_q     <= '0;
			searching_q <= 1'b0;
			found_q     <= 1'b0;
			chk_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_node || emit_end) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (push_en) begin
				visited_q[push_node] <= 1'b1;
				depth_q              <= depth_q + DEPTH_W'(1);
			end
			chk_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_TRAVERSE) begin
						visited_q   <= '0;
						depth_q     <= '0;
						outer_q     <= '0;
						searching_q <= 1'b0;
						found_q     <= 1'b0;
						state_q     <= S_OUTER;
					end else if (accept && operation == OP_SEARCH) begin
						visited_q   <= NODES'(1) << node;
						depth_q     <= DEPTH_W'(1);
						searching_q <= 1'b1;
						found_q     <= 1'b0;
						state_q     <= S_POP;
					end
				end
				S_OUTER: begin
					if (outer_done) begin
						state_q <= S_END;
					end else begin
						outer_q <= outer_q + DEPTH_W'(1);
						if (push_en) begin
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					if (depth_q == '0) begin
						state_q <= searching_q ? S_END : S_OUTER;
					end else begin
						depth_q <= depth_q - DEPTH_W'(1);
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					if (searching_q && stk_rdata == goal_q) begin
						found_q <= 1'b1;
						depth_q <= '0;
						state_q <= S_END;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_node) begin
						state_q <= S_NB;
					end
				end
				S_NB: begin
					// one neighbor read issued per cycle, checked the next
					chk_s1 <= (k_q != '0);
					if (k_q == '0) begin
						state_q <= S_POP;
					end
				end
				S_END: begin
					if (emit_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			goal_q <= goal;
		end
		if (state_q == S_TOP) begin
			cur_q <= stk_rdata;
		end
		if (emit_node) begin
			k_q <= deg_rdata;
		end else if (state_q == S_NB && k_q != '0) begin
			k_q <= k_q - DEG_W'(1);
		end
		if (emit_node) begin
			kind_q      <= KIND_NODE;
			node_q      <= cur_q;
			found_out_q <= 1'b0;
			last_q      <= 1'b0;
		end else if (emit_end) begin
			kind_q      <= KIND_END;
			node_q      <= '0;
			found_out_q <= found_q;
			last_q      <= 1'b1;
		end
	end

	assign res_valid    = res_valid_q;
	assign kind         = kind_q;
	assign visited_node = node_q;
	assign goal_found   = found_out_q;
	assign last         = last_q;

endmodule

// ----- sv/dfw_chk.sv -----
// port-level checks for the walker, bound to the top level
// depends on dfw_pkg and graph_depth_first_walker_top

module dfw_chk
	import dfw_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic [1:0] operation,
	input logic [4:0] node,
	input logic [2:0] slot,
	input logic [4:0] neighbor,
	input logic [3:0] degree,
	input logic [4:0] goal,
	input logic       res_valid,
	input logic       res_stall,
	input logic       kind,
	input logic [4:0] visited_node,
	input logic       goal_found,
	input logic       last
);

	// a run keeps the request side busy afterwards
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (operation == OP_TRAVERSE || operation == OP_SEARCH))
		|=> req_stall)
		else $error("run request did not make the block busy");

	// table writes leave the block ready for the next request
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (operation == OP_NB_WRITE || operation == OP_DEG_WRITE))
		|=> !req_stall)
		else $error("table write stalled the request side");

	// node results carry no end flags, end results carry node zero and last
	a_res_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((kind == KIND_END) ? (last && visited_node == '0)
		                                  : (!last && !goal_found)))
		else $error("result fields inconsistent with kind");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(kind) && $stable(visited_node)
		                              && $stable(goal_found) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind graph_depth_first_walker_top dfw_chk u_chk (.*);

// ----- tb/dfw_checker.sv -----
// result checker for the depth-first graph walker: mirrors the adjacency tables,
// predicts every walk and compares each accepted result field by field
// depends on dfw_pkg

module dfw_checker
	import dfw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_stall,
	input  logic [1:0] operation,
	input  logic [4:0] node,
	input  logic [2:0] slot,
	input  logic [4:0] neighbor,
	input  logic [3:0] degree,
	input  logic [4:0] goal,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic       kind,
	input  logic [4:0] visited_node,
	input  logic       goal_found,
	input  logic       last,
	output int         mismatches,
	output int         expected_left
);

	typedef struct packed {
		logic              kind;
		logic [NODE_W-1:0] node;
		logic              found;
		logic              last;
	} walk_res_t;

	// shadow copies of the adjacency tables
	logic [NODE_W-1:0] nb_mem  [NODES*MAX_DEGREE];
	logic [DEG_W-1:0]  deg_mem [NODES];

	// walk state
	logic              seen [NODES];
	logic [NODE_W-1:0] walk_stk [$];
	walk_res_t         walk_results_q [$];
	walk_res_t         want_res;
	bit                search_hit;
	bit                unused_hit;

	function automatic walk_res_t make_result(input logic k, input logic [NODE_W-1:0] n,
		input logic f, input logic l);
		walk_res_t r;
		r.kind  = k;
		r.node  = n;
		r.found = f;
		r.last  = l;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// explicit-stack walk from one root, marking nodes as they are pushed
	task automatic walk_from(input logic [NODE_W-1:0] root, input logic [NODE_W-1:0] target,
		input bit searching, output bit hit);
		logic [NODE_W-1:0] cur;
		logic [NODE_W-1:0] nbr;
		hit = 1'b0;
		seen[root] = 1'b1;
		walk_stk = {walk_stk, root};
		while (walk_stk.size() > 0 && !hit) begin
			cur = walk_stk.pop_back();
			if (searching && cur == target) begin
				walk_stk.delete();
				hit = 1'b1;
			end else begin
				walk_results_q = {walk_results_q, make_result(KIND_NODE, cur, 1'b0, 1'b0)};
				// last neighbor pushed first so the first-listed one pops first
				for (int k = deg_mem[cur]; k > 0; k--) begin
					nbr = nb_mem[cur*MAX_DEGREE + k - 1];
					if (!seen[nbr]) begin
						seen[nbr] = 1'b1;
						walk_stk = {walk_stk, nbr};
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				deg_mem[i] = '0;
			end
			for (int i = 0; i < NODES*MAX_DEGREE; i++) begin
				nb_mem[i] = '0;
			end
			walk_results_q.delete();
			mismatches    = 0;
			expected_left <= 0;
		end else begin
			// compare an accepted result with the oldest expectation
			if (res_valid && !res_stall) begin
				if (walk_results_q.size() == 0) begin
					report_mismatch($sformatf("result with none pending: kind %0d node %0d",
						kind, visited_node));
				end else begin
					want_res = walk_results_q.pop_front();
					if (kind !== want_res.kind)
						report_mismatch($sformatf("kind got %0d expected %0d",
							kind, want_res.kind));
					if (visited_node !== want_res.node)
						report_mismatch($sformatf("visited_node got %0d expected %0d",
							visited_node, want_res.node));
					if (goal_found !== want_res.found)
						report_mismatch($sformatf("goal_found got %0d expected %0d",
							goal_found, want_res.found));
					if (last !== want_res.last)
						report_mismatch($sformatf("last got %0d expected %0d",
							last, want_res.last));
				end
			end

			// apply an accepted request to the shadow tables or predict its run
			if (req_valid && !req_stall) begin
				case (operation)
					OP_NB_WRITE: begin
						nb_mem[node*MAX_DEGREE + slot] = neighbor;
					end
					OP_DEG_WRITE: begin
						deg_mem[node] = (degree > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(degree);
					end
					default: begin
						for (int i = 0; i < NODES; i++) begin
							seen[i] = 1'b0;
						end
						walk_stk.delete();
						search_hit = 1'b0;
						if (operation == OP_TRAVERSE) begin
							for (int r = 0; r < NODES; r++) begin
								if (!seen[r])
									walk_from(NODE_W'(r), '0, 1'b0, unused_hit);
							end
						end else begin
							walk_from(node, goal, 1'b1, search_hit);
						end
						walk_results_q = {walk_results_q,
							make_result(KIND_END, '0, search_hit, 1'b1)};
					end
				endcase
			end

			expected_left <= walk_results_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// testbench top for the depth-first graph walker: clock, reset, request stimulus,
// result-side stalls and the final verdict
// depends on dfw_pkg, graph_depth_first_walker_top and dfw_checker

module tb_top;
	import dfw_pkg::*;

	localparam int TOTAL_ITEMS     = 210;
	localparam int PRESSURE_CYCLES = 400;
	localparam int TAIL_CYCLES     = 60;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       req_valid    = 1'b0;
	logic       req_stall;
	logic [1:0] operation    = '0;
	logic [4:0] node         = '0;
	logic [2:0] slot         = '0;
	logic [4:0] neighbor     = '0;
	logic [3:0] degree       = '0;
	logic [4:0] goal         = '0;
	logic       res_valid;
	logic       res_stall    = 1'b0;
	logic       kind;
	logic [4:0] visited_node;
	logic       goal_found;
	logic       last;

	int mismatches;
	int expected_left;
	int items_sent       = 0;
	bit hold_off_pending = 1'b0;
	bit no_idle          = 1'b0;

	// slots written so far per node; degrees never reach past the written prefix
	logic [MAX_DEGREE-1:0] slots_loaded [NODES];

	always #4 clk = ~clk;

	graph_depth_first_walker_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.node         (node),
		.slot         (slot),
		.neighbor     (neighbor),
		.degree       (degree),
		.goal         (goal),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.visited_node (visited_node),
		.goal_found   (goal_found),
		.last         (last)
	);

	dfw_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.node          (node),
		.slot          (slot),
		.neighbor      (neighbor),
		.degree        (degree),
		.goal          (goal),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.kind          (kind),
		.visited_node  (visited_node),
		.goal_found    (goal_found),
		.last          (last),
		.mismatches    (mismatches),
		.expected_left (expected_left)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offer one request and hold it until accepted
	task automatic send_req(input logic [1:0] op, input logic [4:0] n, input logic [2:0] s,
		input logic [4:0] nb, input logic [3:0] d, input logic [4:0] g);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		node      <= n;
		slot      <= s;
		neighbor  <= nb;
		degree    <= d;
		goal      <= g;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (op == OP_NB_WRITE)
			slots_loaded[n][s] = 1'b1;
		items_sent++;
	endtask

	// request helpers, unused fields carry random noise
	task automatic load_neighbor(input int n, input int s, input int nb);
		send_req(OP_NB_WRITE, 5'(n), 3'(s), 5'(nb), 4'($urandom()), 5'($urandom()));
	endtask

	task automatic set_degree(input int n, input int d);
		send_req(OP_DEG_WRITE, 5'(n), 3'($urandom()), 5'($urandom()), 4'(d), 5'($urandom()));
	endtask

	task automatic run_traverse();
		send_req(OP_TRAVERSE, 5'($urandom()), 3'($urandom()), 5'($urandom()),
			4'($urandom()), 5'($urandom()));
	endtask

	task automatic run_search(input int start, input int target);
		send_req(OP_SEARCH, 5'(start), 3'($urandom()), 5'($urandom()),
			4'($urandom()), 5'(target));
	endtask

	// result side: random stalls plus a long hold-off each time one is requested
	initial begin
		int run_len;
		int hold;
		@(posedge clk);
		forever begin
			if (hold_off_pending) begin
				res_stall <= 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
				hold_off_pending = 1'b0;
			end
			run_len = $urandom_range(1, 12);
			res_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
			hold = no_idle ? 0 : pick_gap();
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// request stimulus and verdict
	initial begin
		int hub_list [MAX_DEGREE];
		int pick;
		int n;
		int k;
		int prefix;
		int start;
		bit pressure_done;
		hub_list = '{1, 2, 3, 31, 0, 4, 5, 6};
		pressure_done = 1'b0;
		for (int i = 0; i < NODES; i++) begin
			slots_loaded[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full neighbor list with a self loop, extreme indexes,
		// saturating degree, zero degree, found / missing goal, start equals goal
		for (int s = 0; s < MAX_DEGREE; s++) begin
			load_neighbor(0, s, hub_list[s]);
		end
		load_neighbor(31, 0, 30);
		load_neighbor(31, 7, 31);
		set_degree(0, 15);
		set_degree(31, 1);
		set_degree(30, 0);
		hold_off_pending = 1'b1;
		run_traverse();
		run_search(0, 30);
		run_search(7, 7);
		run_search(0, 20);
		run_search(9, 3);

		// random: mostly node list builds followed by runs, some stray writes
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				no_idle = !no_idle;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				n = $urandom_range(0, NODES-1);
				k = $urandom_range(0, MAX_DEGREE);
				for (int s = 0; s < k; s++) begin
					load_neighbor(n, s, $urandom_range(0, NODES-1));
				end
				set_degree(n, (k == MAX_DEGREE) ? $urandom_range(MAX_DEGREE, 15) : k);
			end else if (pick < 58) begin
				load_neighbor($urandom_range(0, NODES-1), $urandom_range(0, MAX_DEGREE-1),
					$urandom_range(0, NODES-1));
			end else if (pick < 65) begin
				n = $urandom_range(0, NODES-1);
				prefix = 0;
				while (prefix < MAX_DEGREE && slots_loaded[n][prefix])
					prefix++;
				set_degree(n, (prefix == MAX_DEGREE) ? $urandom_range(0, 15)
					: $urandom_range(0, prefix));
			end else if (pick < 80) begin
				if (!pressure_done && items_sent > 120) begin
					hold_off_pending = 1'b1;
					pressure_done    = 1'b1;
				end
				run_traverse();
			end else begin
				start = $urandom_range(0, NODES-1);
				run_search(start, ($urandom_range(0, 4) == 0) ? start : $urandom_range(0, NODES-1));
			end
		end
		req_valid <= 1'b0;

		// drain the outstanding results, then give stray ones a chance to show
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/dfw_pkg.sv
sv/dfw_adj.sv
sv/dfw_stack.sv
sv/dfw_ctrl.sv
sv/graph_depth_first_walker_top.sv
sv/dfw_chk.sv
tb/dfw_checker.sv
tb/tb_top.sv
